### design/ecpa_pkg.sv
// shared types and constants for the elliptic-curve point unit
package ecpa_pkg;

  localparam int SCALAR_BITS = 16;
  localparam int CFG_IDX_BITS = 1;

  localparam logic [CFG_IDX_BITS-1:0] REG_CURVE_A = 1'b0;
  localparam logic [CFG_IDX_BITS-1:0] REG_MODULUS = 1'b1;

  typedef enum logic [1:0] {
    OP_ADD,
    OP_SUB,
    OP_MUL,
    OP_DIV
  } alu_op_t;

  typedef struct packed {
    logic    start;
    alu_op_t op;
  } alu_req_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_RED_A,
    S_RED_PX,
    S_RED_PY,
    S_RED_QX,
    S_RED_QY,
    S_INIT,
    S_ADD_BEGIN,
    S_EQ_SQ,
    S_EQ_3A,
    S_EQ_3B,
    S_EQ_NUM,
    S_EQ_DEN,
    S_NE_NUM,
    S_NE_DEN,
    S_INV_TEST,
    S_INV_DIV,
    S_INV_MUL,
    S_INV_SUB,
    S_K,
    S_KK,
    S_X3A,
    S_X3B,
    S_Y3A,
    S_Y3B,
    S_Y3C,
    S_LOOP,
    S_OUT
  } state_t;

endpackage

### design/ecpa_in_if.sv
// input word channel: operation mode, two points and a scalar
interface ecpa_in_if #(
  parameter int W = 16
);
  import ecpa_pkg::*;
  logic                   valid;
  logic                   ready;
  logic                   mode;
  logic [W-1:0]           px;
  logic [W-1:0]           py;
  logic [W-1:0]           qx;
  logic [W-1:0]           qy;
  logic [SCALAR_BITS-1:0] scalar;

  modport source (output valid, mode, px, py, qx, qy, scalar, input ready);
  modport sink (input valid, mode, px, py, qx, qy, scalar, output ready);
endinterface

### design/ecpa_out_if.sv
// result word channel: result point and missing-inverse flag
interface ecpa_out_if #(
  parameter int W = 16
);
  logic         valid;
  logic         ready;
  logic [W-1:0] rx;
  logic [W-1:0] ry;
  logic         no_inverse;

  modport source (output valid, rx, ry, no_inverse, input ready);
  modport sink (input valid, rx, ry, no_inverse, output ready);
endinterface

### design/ec_point_add_scalar_mul.sv
// top level: affine point add and scalar multiply over a prime field
// add mode: five reductions, then one point add with one inversion by extended euclid
// each euclid step is a divide, a multiply, a subtract and a test
// scalar mode: three reductions, then up to (scalar-1) adds, each with one inversion
// throughput: one word at a time, input taken again once the result sits in the output register
// synchronous active-low reset: curve_a=4, modulus=29, sequencer idle, no result
module ec_point_add_scalar_mul
  import ecpa_pkg::*;
#(
  parameter int FIELD_BITS = 16
) (
  input  logic                    clk,
  input  logic                    rst_n,
  ecpa_in_if.sink                 in_ch,
  ecpa_out_if.source              out_ch,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_BITS-1:0] cfg_idx,
  input  logic [FIELD_BITS-1:0]   cfg_wdata
);

  localparam int W = FIELD_BITS;
  localparam logic [W-1:0] ONE = W'(1);

  // configuration registers
  logic [W-1:0] curve_a_r, mod_r;

  // sequencer
  state_t state_r, state_nxt;
  logic   issued_r;

  // working registers: r holds the running point, q the addend
  logic                   mode_r, err_r;
  logic [SCALAR_BITS-1:0] n_r, cnt_r, cnt_inc;
  logic [W-1:0] a_r, px_r, py_r, qx_r, qy_r, rx_r, ry_r;
  logic [W-1:0] num_r, tmp_r, k_r, x3_r, q_r, rem_r;
  logic [W-1:0] r0_r, r1_r, t0_r, t1_r;

  // output register
  logic         out_valid_r;
  logic [W-1:0] out_rx_r, out_ry_r;
  logic         out_err_r;

  // alu hookup
  logic         alu_use, alu_done;
  alu_op_t      alu_op;
  alu_req_t     alu_req;
  logic [W-1:0] alu_a, alu_b, alu_res, alu_quo;
  logic         out_free, pt_equal;

  assign cnt_inc  = cnt_r + SCALAR_BITS'(1);
  assign out_free = !out_valid_r || out_ch.ready;
  assign pt_equal = (rx_r == qx_r) && (ry_r == qy_r);

  ecpa_alu #(.W(W)) u_alu (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (alu_req),
    .opa  (alu_a),
    .opb  (alu_b),
    .modv (mod_r),
    .done (alu_done),
    .res  (alu_res),
    .quo  (alu_quo)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          state_nxt = (mod_r < W'(2)) ? S_OUT : S_RED_A;
        end
      end
      S_RED_A:  if (alu_done) state_nxt = S_RED_PX;
      S_RED_PX: if (alu_done) state_nxt = S_RED_PY;
      S_RED_PY: if (alu_done) state_nxt = mode_r ? S_INIT : S_RED_QX;
      S_RED_QX: if (alu_done) state_nxt = S_RED_QY;
      S_RED_QY: if (alu_done) state_nxt = S_INIT;
      S_INIT: begin
        if (!mode_r || (SCALAR_BITS'(1) < n_r)) begin
          state_nxt = S_ADD_BEGIN;
        end else begin
          state_nxt = S_OUT;
        end
      end
      S_ADD_BEGIN: state_nxt = pt_equal ? S_EQ_SQ : S_NE_NUM;
      S_EQ_SQ:  if (alu_done) state_nxt = S_EQ_3A;
      S_EQ_3A:  if (alu_done) state_nxt = S_EQ_3B;
      S_EQ_3B:  if (alu_done) state_nxt = S_EQ_NUM;
      S_EQ_NUM: if (alu_done) state_nxt = S_EQ_DEN;
      S_EQ_DEN: if (alu_done) state_nxt = S_INV_TEST;
      S_NE_NUM: if (alu_done) state_nxt = S_NE_DEN;
      S_NE_DEN: if (alu_done) state_nxt = S_INV_TEST;
      S_INV_TEST: begin
        if (r1_r != '0) begin
          state_nxt = S_INV_DIV;
        end else begin
          state_nxt = (r0_r == ONE) ? S_K : S_OUT;
        end
      end
      S_INV_DIV: if (alu_done) state_nxt = S_INV_MUL;
      S_INV_MUL: if (alu_done) state_nxt = S_INV_SUB;
      S_INV_SUB: if (alu_done) state_nxt = S_INV_TEST;
      S_K:   if (alu_done) state_nxt = S_KK;
      S_KK:  if (alu_done) state_nxt = S_X3A;
      S_X3A: if (alu_done) state_nxt = S_X3B;
      S_X3B: if (alu_done) state_nxt = S_Y3A;
      S_Y3A: if (alu_done) state_nxt = S_Y3B;
      S_Y3B: if (alu_done) state_nxt = S_Y3C;
      S_Y3C: if (alu_done) state_nxt = S_LOOP;
      S_LOOP: state_nxt = (mode_r && (cnt_inc < n_r)) ? S_ADD_BEGIN : S_OUT;
      S_OUT:  if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // alu operand selection per micro-step
  always_comb begin
    alu_use = 1'b0;
    alu_op  = OP_ADD;
    alu_a   = '0;
    alu_b   = '0;
    case (state_r)
      S_RED_A:    begin alu_use = 1'b1; alu_op = OP_MUL; alu_a = curve_a_r; alu_b = ONE; end
      S_RED_PX:   begin alu_use = 1'b1; alu_op = OP_MUL; alu_a = px_r; alu_b = ONE; end
      S_RED_PY:   begin alu_use = 1'b1; alu_op = OP_MUL; alu_a = py_r; alu_b = ONE; end
      S_RED_QX:   begin alu_use = 1'b1; alu_op = OP_MUL; alu_a = qx_r; alu_b = ONE; end
      S_RED_QY:   begin alu_use = 1'b1; alu_op = OP_MUL; alu_a = qy_r; alu_b = ONE; end
      S_EQ_SQ:    begin alu_use = 1'b1; alu_op = OP_MUL; alu_a = rx_r; alu_b = rx_r; end
      S_EQ_3A:    begin alu_use = 1'b1; alu_op = OP_ADD; alu_a = tmp_r; alu_b = tmp_r; end
      S_EQ_3B:    begin alu_use = 1'b1; alu_op = OP_ADD; alu_a = num_r; alu_b = tmp_r; end
      S_EQ_NUM:   begin alu_use = 1'b1; alu_op = OP_ADD; alu_a = num_r; alu_b = a_r; end
      S_EQ_DEN:   begin alu_use = 1'b1; alu_op = OP_ADD; alu_a = ry_r; alu_b = ry_r; end
      S_NE_NUM:   begin alu_use = 1'b1; alu_op = OP_SUB; alu_a = qy_r; alu_b = ry_r; end
      S_NE_DEN:   begin alu_use = 1'b1; alu_op = OP_SUB; alu_a = qx_r; alu_b = rx_r; end
      S_INV_DIV:  begin alu_use = 1'b1; alu_op = OP_DIV; alu_a = r0_r; alu_b = r1_r; end
      S_INV_MUL:  begin alu_use = 1'b1; alu_op = OP_MUL; alu_a = q_r; alu_b = t1_r; end
      S_INV_SUB:  begin alu_use = 1'b1; alu_op = OP_SUB; alu_a = t0_r; alu_b = tmp_r; end
      S_K:        begin alu_use = 1'b1; alu_op = OP_MUL; alu_a = num_r; alu_b = t0_r; end
      S_KK:       begin alu_use = 1'b1; alu_op = OP_MUL; alu_a = k_r; alu_b = k_r; end
      S_X3A:      begin alu_use = 1'b1; alu_op = OP_SUB; alu_a = tmp_r; alu_b = rx_r; end
      S_X3B:      begin alu_use = 1'b1; alu_op = OP_SUB; alu_a = tmp_r; alu_b = qx_r; end
      S_Y3A:      begin alu_use = 1'b1; alu_op = OP_SUB; alu_a = rx_r; alu_b = x3_r; end
      S_Y3B:      begin alu_use = 1'b1; alu_op = OP_MUL; alu_a = k_r; alu_b = tmp_r; end
      S_Y3C:      begin alu_use = 1'b1; alu_op = OP_SUB; alu_a = tmp_r; alu_b = ry_r; end
      default:    alu_use = 1'b0;
    endcase
  end

  // one start per alu step, then wait for done
  assign alu_req.start = alu_use && !issued_r;
  assign alu_req.op    = alu_op;

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      issued_r    <= 1'b0;
      out_valid_r <= 1'b0;
      curve_a_r   <= W'(4);
      mod_r       <= W'(29);
    end else begin
      state_r <= state_nxt;
      if (alu_done) begin
        issued_r <= 1'b0;
      end else if (alu_req.start) begin
        issued_r <= 1'b1;
      end
      if (state_r == S_OUT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_we) begin
        case (cfg_idx)
          REG_CURVE_A: curve_a_r <= cfg_wdata;
          REG_MODULUS: mod_r     <= cfg_wdata;
          default:     ;
        endcase
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          mode_r <= in_ch.mode;
          px_r   <= in_ch.px;
          py_r   <= in_ch.py;
          qx_r   <= in_ch.qx;
          qy_r   <= in_ch.qy;
          n_r    <= in_ch.scalar;
          cnt_r  <= SCALAR_BITS'(1);
          err_r  <= (mod_r < W'(2));
        end
      end
      S_RED_A:  if (alu_done) a_r  <= alu_res;
      S_RED_PX: if (alu_done) px_r <= alu_res;
      S_RED_PY: if (alu_done) py_r <= alu_res;
      S_RED_QX: if (alu_done) qx_r <= alu_res;
      S_RED_QY: if (alu_done) qy_r <= alu_res;
      S_INIT: begin
        rx_r <= px_r;
        ry_r <= py_r;
        if (mode_r) begin
          qx_r <= px_r;
          qy_r <= py_r;
        end
      end
      S_EQ_SQ:  if (alu_done) tmp_r <= alu_res;
      S_EQ_3A:  if (alu_done) num_r <= alu_res;
      S_EQ_3B:  if (alu_done) num_r <= alu_res;
      S_EQ_NUM: if (alu_done) num_r <= alu_res;
      S_NE_NUM: if (alu_done) num_r <= alu_res;
      S_EQ_DEN, S_NE_DEN: begin
        // start extended euclid: r0=m, r1=den, t0=0, t1=1
        if (alu_done) begin
          r1_r <= alu_res;
          r0_r <= mod_r;
          t0_r <= '0;
          t1_r <= ONE;
        end
      end
      S_INV_TEST: begin
        if (r1_r == '0 && r0_r != ONE) begin
          err_r <= 1'b1;
        end
      end
      S_INV_DIV: begin
        if (alu_done) begin
          q_r   <= alu_quo;
          rem_r <= alu_res;
        end
      end
      S_INV_MUL: if (alu_done) tmp_r <= alu_res;
      S_INV_SUB: begin
        if (alu_done) begin
          r0_r <= r1_r;
          r1_r <= rem_r;
          t0_r <= t1_r;
          t1_r <= alu_res;
        end
      end
      S_K:   if (alu_done) k_r   <= alu_res;
      S_KK:  if (alu_done) tmp_r <= alu_res;
      S_X3A: if (alu_done) tmp_r <= alu_res;
      S_X3B: if (alu_done) x3_r  <= alu_res;
      S_Y3A: if (alu_done) tmp_r <= alu_res;
      S_Y3B: if (alu_done) tmp_r <= alu_res;
      S_Y3C: begin
        if (alu_done) begin
          rx_r <= x3_r;
          ry_r <= alu_res;
        end
      end
      S_LOOP: cnt_r <= cnt_inc;
      S_OUT: begin
        if (out_free) begin
          out_rx_r  <= err_r ? '0 : rx_r;
          out_ry_r  <= err_r ? '0 : ry_r;
          out_err_r <= err_r;
        end
      end
      default: ;
    endcase
  end

  assign in_ch.ready       = (state_r == S_IDLE);
  assign out_ch.valid      = out_valid_r;
  assign out_ch.rx         = out_rx_r;
  assign out_ch.ry         = out_ry_r;
  assign out_ch.no_inverse = out_err_r;

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_err_r) |-> (out_rx_r == '0 && out_ry_r == '0))
    else $error("error word carries nonzero point");
  a_done_in_alu_state: assert property (@(posedge clk) disable iff (!rst_n)
    alu_done |-> alu_use) else $error("alu result arrived outside an alu step");
  a_issue_once: assert property (@(posedge clk) disable iff (!rst_n)
    (issued_r && !alu_done) |=> (state_r == $past(state_r)))
    else $error("sequencer left a step before its alu result");
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ADD_BEGIN && mode_r) |-> cnt_r < n_r)
    else $error("point add beyond scalar count");

endmodule

### design/ecpa_alu.sv
// shared modular arithmetic unit: add, subtract, bit-serial multiply and divide
module ecpa_alu
  import ecpa_pkg::*;
#(
  parameter int W = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  input  alu_req_t     req,
  input  logic [W-1:0] opa,
  input  logic [W-1:0] opb,
  input  logic [W-1:0] modv,
  output logic         done,
  output logic [W-1:0] res,
  output logic [W-1:0] quo
);

  localparam int CW = $clog2(W);
  localparam logic [CW-1:0] LAST = CW'(W - 1);

  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  alu_op_t       op_r, op_nxt;
  logic [W-1:0]  a_r, a_nxt;
  logic [W-1:0]  b_r, b_nxt;
  logic [W-1:0]  acc_r, acc_nxt;
  logic [W-1:0]  quo_r, quo_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  logic          bit_in;
  logic [W:0]    dbl, dbl_red, sum, sum_red, rr, qs, qd;
  logic [W-1:0]  mul_step, div_step, add_res, sub_res;
  logic          div_ge;

  assign bit_in = a_r[W-1];

  always_comb begin
    // multiply step: acc = 2*acc + bit*b, both halves reduced once
    dbl      = {acc_r, 1'b0};
    dbl_red  = (dbl >= {1'b0, modv}) ? dbl - {1'b0, modv} : dbl;
    sum      = dbl_red + (bit_in ? {1'b0, b_r} : '0);
    sum_red  = (sum >= {1'b0, modv}) ? sum - {1'b0, modv} : sum;
    mul_step = sum_red[W-1:0];
    // restoring division step
    rr       = {acc_r, bit_in};
    div_ge   = rr >= {1'b0, b_r};
    div_step = div_ge ? W'(rr - {1'b0, b_r}) : rr[W-1:0];
    // combinational add and subtract of residues
    qs       = {1'b0, opa} + {1'b0, opb};
    add_res  = (qs >= {1'b0, modv}) ? W'(qs - {1'b0, modv}) : qs[W-1:0];
    qd       = {1'b0, opa} + {1'b0, modv} - {1'b0, opb};
    sub_res  = (opa >= opb) ? (opa - opb) : qd[W-1:0];
  end

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    op_nxt   = op_r;
    a_nxt    = a_r;
    b_nxt    = b_r;
    acc_nxt  = acc_r;
    quo_nxt  = quo_r;
    cnt_nxt  = cnt_r;
    if (req.start) begin
      op_nxt  = req.op;
      a_nxt   = opa;
      b_nxt   = opb;
      quo_nxt = '0;
      cnt_nxt = '0;
      case (req.op)
        OP_ADD: begin
          acc_nxt  = add_res;
          done_nxt = 1'b1;
        end
        OP_SUB: begin
          acc_nxt  = sub_res;
          done_nxt = 1'b1;
        end
        default: begin
          acc_nxt  = '0;
          busy_nxt = 1'b1;
        end
      endcase
    end else if (busy_r) begin
      a_nxt   = {a_r[W-2:0], 1'b0};
      cnt_nxt = cnt_r + CW'(1);
      if (op_r == OP_DIV) begin
        acc_nxt = div_step;
        quo_nxt = {quo_r[W-2:0], div_ge};
      end else begin
        acc_nxt = mul_step;
      end
      if (cnt_r == LAST) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      op_r   <= OP_ADD;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      op_r   <= op_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    acc_r <= acc_nxt;
    quo_r <= quo_nxt;
  end

  assign done = done_r;
  assign res  = acc_r;
  assign quo  = quo_r;

  a_no_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    req.start |-> !busy_r) else $error("alu started while busy");
  a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r) else $error("alu done while still iterating");
  a_mul_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    (done_r && op_r == OP_MUL && modv > W'(1)) |-> acc_r < modv)
    else $error("product not reduced");

endmodule

### tb/sv/tb_ec_point_add_scalar_mul.sv
// testbench for the elliptic-curve point add and scalar multiply unit
module tb_ec_point_add_scalar_mul;
  import ecpa_pkg::*;

  localparam int W = 16;

  // one expected result word
  typedef struct {
    logic [W-1:0] rx;
    logic [W-1:0] ry;
    logic         no_inverse;
  } point_res_t;

  // one row of the directed table; typed rows carry their result by hand
  typedef struct {
    logic                   mode;
    logic [W-1:0]           px;
    logic [W-1:0]           py;
    logic [W-1:0]           qx;
    logic [W-1:0]           qy;
    logic [SCALAR_BITS-1:0] scalar;
    bit                     typed;
    point_res_t             res;
  } stim_row_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         cfg_we = 1'b0;
  logic [CFG_IDX_BITS-1:0] cfg_idx = REG_CURVE_A;
  logic [W-1:0] cfg_wdata = '0;

  ecpa_in_if #(.W(W))  in_ch ();
  ecpa_out_if #(.W(W)) out_ch ();

  ec_point_add_scalar_mul #(.FIELD_BITS(W)) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_wdata(cfg_wdata)
  );

  always #5 clk = ~clk;

  // shadow of the curve registers
  logic [W-1:0] shadow_a = 16'd4;
  logic [W-1:0] shadow_m = 16'd29;

  point_res_t pending_points[$];
  int         mismatch_count = 0;
  bit         hold_request = 1'b0;
  bit         directed_typed = 1'b0;
  point_res_t directed_res;

  // inverse of v mod m by extended euclid; 0 when none exists
  function automatic bit mod_inverse(longint v, longint m, output longint inv);
    longint r0, r1, r2, t0, t1, t2, qt;
    r0 = m; r1 = v; t0 = 0; t1 = 1; inv = 0;
    while (r1 != 0) begin
      qt = r0 / r1;
      r2 = r0 - qt * r1;
      t2 = t0 - qt * t1;
      r0 = r1; r1 = r2;
      t0 = t1; t1 = t2;
    end
    if (r0 != 1) return 1'b0;
    t0 = t0 % m;
    if (t0 < 0) t0 += m;
    inv = t0;
    return 1'b1;
  endfunction

  // affine sum of two reduced points; 0 at the point at infinity
  function automatic bit chord_or_tangent(longint x1, longint y1, longint x2, longint y2,
                                          longint a, longint m,
                                          output longint x3, output longint y3);
    longint num, den, iv, k;
    x3 = 0; y3 = 0;
    if (x1 == x2 && y1 == y2) begin
      num = ((x1 * x1) % m * 3 + a) % m;
      den = (2 * y1) % m;
    end else begin
      num = (y2 + m - y1) % m;
      den = (x2 + m - x1) % m;
    end
    if (!mod_inverse(den, m, iv)) return 1'b0;
    k  = (num * iv) % m;
    x3 = ((k * k) % m + 2 * m - x1 - x2) % m;
    y3 = ((k * ((x1 + m - x3) % m)) % m + m - y1) % m;
    return 1'b1;
  endfunction

  function automatic point_res_t predict_point(logic mode, logic [W-1:0] px, logic [W-1:0] py,
                                               logic [W-1:0] qx, logic [W-1:0] qy,
                                               logic [SCALAR_BITS-1:0] scalar);
    point_res_t res;
    longint m, a, x1, y1, rx, ry;
    bit ok;
    m = longint'(shadow_m);
    ok = 1'b1;
    rx = 0; ry = 0;
    if (m < 2) begin
      ok = 1'b0;
    end else begin
      a  = longint'(shadow_a) % m;
      x1 = longint'(px) % m;
      y1 = longint'(py) % m;
      if (mode == 1'b0) begin
        ok = chord_or_tangent(x1, y1, longint'(qx) % m, longint'(qy) % m, a, m, rx, ry);
      end else begin
        rx = x1; ry = y1;
        for (int i = 1; i < int'(scalar) && ok; i++)
          ok = chord_or_tangent(rx, ry, x1, y1, a, m, rx, ry);
      end
    end
    res.rx = ok ? rx[W-1:0] : '0;
    res.ry = ok ? ry[W-1:0] : '0;
    res.no_inverse = !ok;
    return res;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
    mismatch_count++;
  endtask

  // result checker: each accepted word against the oldest expectation
  always @(posedge clk) begin
    point_res_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_points.size() == 0) begin
        report_mismatch("unexpected word rx", longint'(out_ch.rx), longint'(0));
      end else begin
        want = pending_points.pop_front();
        if (out_ch.rx !== want.rx)
          report_mismatch("rx", longint'(out_ch.rx), longint'(want.rx));
        if (out_ch.ry !== want.ry)
          report_mismatch("ry", longint'(out_ch.ry), longint'(want.ry));
        if (out_ch.no_inverse !== want.no_inverse)
          report_mismatch("no_inverse", longint'(out_ch.no_inverse),
                          longint'(want.no_inverse));
      end
    end
  end

  // expectation is taken at the edge the input word is accepted
  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready) begin
      if (directed_typed)
        pending_points.push_back(directed_res);
      else
        pending_points.push_back(predict_point(in_ch.mode, in_ch.px, in_ch.py,
                                               in_ch.qx, in_ch.qy, in_ch.scalar));
    end
  end

  // receiver: random stalls, plus one long hold-off when asked
  initial begin
    int n;
    out_ch.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_request) begin
        out_ch.ready = 1'b0;
        repeat (3000) @(negedge clk);
        hold_request = 1'b0;
      end
      n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 4);
      if (n > 0) begin
        out_ch.ready = 1'b0;
        repeat (n) @(negedge clk);
      end
      out_ch.ready = 1'b1;
      do @(posedge clk); while (!out_ch.valid);
    end
  end

  // offer one word; leaves valid high so a back-to-back word needs no drop
  task automatic send_word(logic mode, logic [W-1:0] px, logic [W-1:0] py,
                           logic [W-1:0] qx, logic [W-1:0] qy,
                           logic [SCALAR_BITS-1:0] scalar, bit typed, point_res_t res);
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 4);
    @(negedge clk);
    if (gap > 0) begin
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.mode = mode;
    in_ch.px = px;
    in_ch.py = py;
    in_ch.qx = qx;
    in_ch.qy = qy;
    in_ch.scalar = scalar;
    directed_typed = typed;
    directed_res = res;
    in_ch.valid = 1'b1;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // wait for the block to drain, then write one register
  task automatic write_curve_reg(logic [CFG_IDX_BITS-1:0] idx, logic [W-1:0] value);
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (pending_points.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    cfg_we = 1'b1;
    cfg_idx = idx;
    cfg_wdata = value;
    @(negedge clk);
    cfg_we = 1'b0;
    if (idx == REG_CURVE_A) shadow_a = value;
    else shadow_m = value;
  endtask

  // random word shaped toward meaningful point arithmetic on the current curve
  task automatic send_random_word();
    logic [W-1:0] m, px, py, qx, qy;
    logic [SCALAR_BITS-1:0] scalar;
    logic mode;
    int pick;
    point_res_t none;
    none = '{default: '0};
    m = (shadow_m < 2) ? 16'd2 : shadow_m;
    mode = 1'($urandom_range(0, 1));
    pick = $urandom_range(0, 19);
    px = (pick < 3) ? W'($urandom_range(0, 65535)) : W'($urandom_range(0, m - 1));
    py = (pick < 3) ? W'($urandom_range(0, 65535)) : W'($urandom_range(0, m - 1));
    if (pick == 3) py = '0;
    qx = W'($urandom_range(0, 65535));
    qy = W'($urandom_range(0, 65535));
    if (mode == 1'b0) begin
      if (pick >= 4 && pick < 9) begin
        // doubling, sometimes through an unreduced copy
        qx = ($urandom_range(0, 1) && px < 65535 - m) ? px + m : px;
        qy = py;
      end else if (pick >= 9 && pick < 12) begin
        // vertical line: q is -p
        qx = px;
        qy = (m - (py % m)) % m;
      end else if (pick >= 12) begin
        qx = W'($urandom_range(0, m - 1));
        qy = W'($urandom_range(0, m - 1));
      end
      scalar = SCALAR_BITS'($urandom_range(0, 65535));
    end else begin
      // long chains only where the modulus keeps each add cheap
      if (shadow_m <= 128 && $urandom_range(0, 7) == 0)
        scalar = SCALAR_BITS'($urandom_range(10, 40));
      else
        scalar = SCALAR_BITS'($urandom_range(0, 10));
    end
    send_word(mode, px, py, qx, qy, scalar, 1'b0, none);
  endtask

  stim_row_t directed_rows[] = '{
    // extremes of the coordinates, predicted
    '{1'b0, 16'hffff, 16'hffff, 16'h0000, 16'h0000, 16'h0000, 1'b0, '{0, 0, 0}},
    '{1'b0, 16'h0000, 16'h0000, 16'hffff, 16'hffff, 16'hffff, 1'b0, '{0, 0, 0}},
    '{1'b0, 16'h0000, 16'h0001, 16'h0001, 16'h0003, 16'h0001, 1'b0, '{0, 0, 0}},
    '{1'b0, 16'h0002, 16'h0006, 16'h0002, 16'h0006, 16'h0001, 1'b0, '{0, 0, 0}},
    // unreduced copy of the same point is a doubling
    '{1'b0, 16'h0002, 16'h0006, 16'h001f, 16'h0023, 16'h0001, 1'b0, '{0, 0, 0}},
    // p plus -p: vertical line, error
    '{1'b0, 16'h0001, 16'h0005, 16'h0001, 16'h0018, 16'h0001, 1'b1, '{0, 0, 1}},
    // doubling a point with y zero: error
    '{1'b0, 16'h0003, 16'h0000, 16'h0003, 16'h0000, 16'h0001, 1'b1, '{0, 0, 1}},
    // scalar one and zero return p reduced
    '{1'b1, 16'd30, 16'd31, 16'hffff, 16'hffff, 16'h0001, 1'b1, '{1, 2, 0}},
    '{1'b1, 16'd30, 16'd31, 16'h0000, 16'h0000, 16'h0000, 1'b1, '{1, 2, 0}},
    // largest scalar stops at once on a y-zero point
    '{1'b1, 16'd3, 16'd29, 16'h0000, 16'h0000, 16'hffff, 1'b1, '{0, 0, 1}},
    '{1'b1, 16'd2, 16'd6, 16'h0000, 16'h0000, 16'd5, 1'b0, '{0, 0, 0}},
    // runs into infinity partway through the chain
    '{1'b1, 16'd2, 16'd6, 16'h0000, 16'h0000, 16'd40, 1'b0, '{0, 0, 0}},
    '{1'b1, 16'hffff, 16'hffff, 16'h0000, 16'h0000, 16'd7, 1'b0, '{0, 0, 0}}
  };

  // curve settings walked by the random part, extremes included
  logic [W-1:0] phase_a[] = '{16'd4, 16'd0, 16'hffff, 16'd7, 16'd2, 16'd123, 16'd1, 16'd9};
  logic [W-1:0] phase_m[] = '{16'd29, 16'hffff, 16'd65521, 16'd3, 16'd97, 16'd1, 16'd0, 16'd2};
  int phase_items[] = '{50, 40, 40, 45, 50, 10, 10, 32};

  initial begin
    in_ch.valid = 1'b0;
    in_ch.mode = 1'b0;
    in_ch.px = '0;
    in_ch.py = '0;
    in_ch.qx = '0;
    in_ch.qy = '0;
    in_ch.scalar = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // directed rows at the reset curve
    foreach (directed_rows[i])
      send_word(directed_rows[i].mode, directed_rows[i].px, directed_rows[i].py,
                directed_rows[i].qx, directed_rows[i].qy, directed_rows[i].scalar,
                directed_rows[i].typed, directed_rows[i].res);

    foreach (phase_a[p]) begin
      write_curve_reg(REG_CURVE_A, phase_a[p]);
      write_curve_reg(REG_MODULUS, phase_m[p]);
      // long receiver hold-off while words keep coming
      if (p == 4) hold_request = 1'b1;
      repeat (phase_items[p]) send_random_word();
    end

    @(negedge clk);
    in_ch.valid = 1'b0;
    while (pending_points.size() != 0) @(negedge clk);
    repeat (50) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // run limit
  initial begin
    #300_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

### sim.f
design/ecpa_pkg.sv
design/ecpa_in_if.sv
design/ecpa_out_if.sv
design/ecpa_alu.sv
design/ec_point_add_scalar_mul.sv
tb/sv/tb_ec_point_add_scalar_mul.sv
